[hw/rtl/rectangle_raster_painter_macros.svh]
// ----------------------------------------------------------------------------
// Rectangle raster painter assertion macros
// Concurrent assertion helpers; defining ASSERT_OFF compiles them away.
// ----------------------------------------------------------------------------
`ifndef RECTANGLE_RASTER_PAINTER_MACROS_SVH
`define RECTANGLE_RASTER_PAINTER_MACROS_SVH

`ifndef ASSERT_OFF
// Same-cycle implication, disabled while reset is active.
`define RRP_ASSERT_IMP(lbl, clk, rstn, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
    else $error("rectangle_raster_painter: assertion failed");
// Next-cycle implication, disabled while reset is active.
`define RRP_ASSERT_NXT(lbl, clk, rstn, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
    else $error("rectangle_raster_painter: assertion failed");
`else
`define RRP_ASSERT_IMP(lbl, clk, rstn, ante, cons)
`define RRP_ASSERT_NXT(lbl, clk, rstn, ante, cons)
`endif

`endif

[hw/rtl/rrp_pkg.sv]
// ----------------------------------------------------------------------------
// Rectangle raster painter package
// Shared constants, operation codes and shape kinds.
// ----------------------------------------------------------------------------
package rrp_pkg;

  // Canvas geometry.
  localparam int SIDE_W    = 8;
  localparam int MAX_SIDE  = 1 << SIDE_W;
  localparam int CNT_W     = SIDE_W + 1;
  localparam int ADDR_W    = 2 * SIDE_W;
  localparam int PIX_W     = 8;

  // Fixed-point coordinates.
  localparam int FRAC_BITS = 8;
  localparam int COORD_W   = 17;
  localparam int BOUND_W   = 20;
  localparam logic signed [BOUND_W-1:0] ONE_UNIT = BOUND_W'(1 << FRAC_BITS);

  // Configuration port.
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 9;
  localparam logic [CFG_IDX_W-1:0] CFG_CANVAS_WIDTH  = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_CANVAS_HEIGHT = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_BACKGROUND    = 2'd2;
  localparam logic [PIX_W-1:0]     BACKGROUND_RESET  = 8'd32;

  // Operation codes.
  typedef enum logic [1:0] {
    OP_CLEAR = 2'd0,
    OP_DRAW  = 2'd1,
    OP_READ  = 2'd2,
    OP_NOP   = 2'd3
  } op_t;

  // Shape kinds.
  localparam logic [7:0] KIND_FILLED  = 8'h52;
  localparam logic [7:0] KIND_OUTLINE = 8'h72;

endpackage

[hw/rtl/rectangle_raster_painter.sv]
// ----------------------------------------------------------------------------
// Rectangle raster painter
// Paints fixed-point rectangles into a 256 by 256 byte canvas held in RAM.
// ----------------------------------------------------------------------------
// Usage: an input transaction carries one operation (clear, draw, read or no
// operation) and produces exactly one output transaction with status and
// pixel. Both channels use valid and stall.
// Timing: the block works on one transaction at a time. A clear writes one
// canvas byte per cycle over the whole 256 by 256 canvas. A valid draw scans
// the canvas in use, one pixel per cycle over the RAM write port. A read
// waits for the registered RAM read. A rejected draw or no operation goes
// straight to the result.
// The output register decouples the sides: a new transaction is accepted
// while a finished result still waits, and that transaction's result is
// held back until the output register is free.
// Reset clears the control state and the configuration registers
// (sizes 0, background 32); the canvas is undefined until the first clear.
// Configuration writes are expected only while the block is idle.
// ----------------------------------------------------------------------------
`include "rectangle_raster_painter_macros.svh"

module rectangle_raster_painter
  import rrp_pkg::*;
(
  input  logic                         clk,
  input  logic                         rst_n,
  // Configuration port.
  input  logic                         cfg_we,
  input  logic [CFG_IDX_W-1:0]         cfg_index,
  input  logic [CFG_DATA_W-1:0]        cfg_wdata,
  // Input channel.
  input  logic                         in_valid,
  output logic                         in_stall,
  input  logic [1:0]                   in_operation,
  input  logic [7:0]                   in_shape_kind,
  input  logic signed [COORD_W-1:0]    in_rect_left,
  input  logic signed [COORD_W-1:0]    in_rect_top,
  input  logic signed [COORD_W-1:0]    in_rect_w,
  input  logic signed [COORD_W-1:0]    in_rect_h,
  input  logic [PIX_W-1:0]             in_color,
  input  logic [SIDE_W-1:0]            in_read_col,
  input  logic [SIDE_W-1:0]            in_read_row,
  // Output channel.
  output logic                         out_valid,
  input  logic                         out_stall,
  output logic                         out_status,
  output logic [PIX_W-1:0]             out_pixel
);

  typedef enum logic [2:0] {
    S_IDLE,
    S_CLEAR,
    S_DRAW,
    S_READ,
    S_FINISH
  } state_t;

  // Control registers.
  state_t              state_r, state_nxt;
  logic [SIDE_W-1:0]   col_r, col_nxt;
  logic [SIDE_W-1:0]   row_r, row_nxt;
  logic                out_valid_r, out_valid_nxt;
  logic [CNT_W-1:0]    cfg_width_r, cfg_width_nxt;
  logic [CNT_W-1:0]    cfg_height_r, cfg_height_nxt;
  logic [PIX_W-1:0]    background_r, background_nxt;

  // Payload registers.
  logic signed [BOUND_W-1:0] left_r, right_r, top_r, bottom_r;
  logic signed [BOUND_W-1:0] left_in_r, right_in_r, top_in_r, bottom_in_r;
  logic                      filled_r;
  logic [PIX_W-1:0]          color_r;
  logic                      in_range_r;
  logic                      res_status_r;
  logic [PIX_W-1:0]          res_pixel_r;
  logic                      out_status_r;
  logic [PIX_W-1:0]          out_pixel_r;

  // Combinational helpers.
  logic                      accept;
  logic                      out_load;
  logic [CNT_W-1:0]          width_use;
  logic [CNT_W-1:0]          height_use;
  logic                      col_last;
  logic                      row_last;
  logic                      draw_bad;
  logic signed [BOUND_W-1:0] ext_left, ext_top, ext_w, ext_h;
  logic signed [BOUND_W-1:0] px, py;
  logic                      in_rect;
  logic                      border;
  logic                      paint;
  logic                      ram_we;
  logic [ADDR_W-1:0]         ram_waddr;
  logic [PIX_W-1:0]          ram_wdata;
  logic [ADDR_W-1:0]         ram_raddr;
  logic [PIX_W-1:0]          ram_rdata;

  // Size registers above the canvas side saturate.
  assign width_use  = (cfg_width_r > CNT_W'(MAX_SIDE)) ? CNT_W'(MAX_SIDE) : cfg_width_r;
  assign height_use = (cfg_height_r > CNT_W'(MAX_SIDE)) ? CNT_W'(MAX_SIDE) : cfg_height_r;

  // Handshake.
  assign in_stall  = (state_r != S_IDLE);
  assign accept    = in_valid && !in_stall;
  assign out_load  = (state_r == S_FINISH) && (!out_valid_r || !out_stall);
  assign out_valid = out_valid_r;
  assign out_status = out_status_r;
  assign out_pixel  = out_pixel_r;

  // Sign-extended rectangle fields and draw validation.
  assign ext_left = BOUND_W'(in_rect_left);
  assign ext_top  = BOUND_W'(in_rect_top);
  assign ext_w    = BOUND_W'(in_rect_w);
  assign ext_h    = BOUND_W'(in_rect_h);
  assign draw_bad = in_rect_w[COORD_W-1] || (in_rect_w == '0) ||
                    in_rect_h[COORD_W-1] || (in_rect_h == '0) ||
                    ((in_shape_kind != KIND_FILLED) && (in_shape_kind != KIND_OUTLINE));

  // Scan position in fixed point and pixel classification.
  assign px      = $signed(BOUND_W'(col_r) << FRAC_BITS);
  assign py      = $signed(BOUND_W'(row_r) << FRAC_BITS);
  assign in_rect = (px >= left_r) && (px <= right_r) && (py >= top_r) && (py <= bottom_r);
  assign border  = (px < left_in_r) || (px > right_in_r) ||
                   (py < top_in_r) || (py > bottom_in_r);
  assign paint   = in_rect && (border || filled_r);

  assign col_last = ({1'b0, col_r} == (width_use - CNT_W'(1)));
  assign row_last = ({1'b0, row_r} == (height_use - CNT_W'(1)));

  // RAM ports. Writes finish before the next transaction is accepted, so a
  // read never overlaps a write to the same entry.
  assign ram_we    = ((state_r == S_DRAW) && paint) || (state_r == S_CLEAR);
  assign ram_waddr = {row_r, col_r};
  assign ram_wdata = (state_r == S_CLEAR) ? background_r : color_r;
  assign ram_raddr = {in_read_row, in_read_col};

  rrp_ram #(
    .DATA_W (PIX_W),
    .DEPTH  (MAX_SIDE * MAX_SIDE),
    .ADDR_W (ADDR_W)
  ) u_canvas (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  // Next-state logic for the sequencer, scan counters and configuration.
  always_comb begin
    state_nxt      = state_r;
    col_nxt        = col_r;
    row_nxt        = row_r;
    out_valid_nxt  = out_valid_r;
    cfg_width_nxt  = cfg_width_r;
    cfg_height_nxt = cfg_height_r;
    background_nxt = background_r;

    if (cfg_we) begin
      unique case (cfg_index)
        CFG_CANVAS_WIDTH:  cfg_width_nxt  = cfg_wdata;
        CFG_CANVAS_HEIGHT: cfg_height_nxt = cfg_wdata;
        CFG_BACKGROUND:    background_nxt = cfg_wdata[PIX_W-1:0];
        default:           ;
      endcase
    end

    if (out_load) begin
      out_valid_nxt = 1'b1;
    end else if (!out_stall) begin
      out_valid_nxt = 1'b0;
    end

    unique case (state_r)
      S_IDLE: begin
        col_nxt = '0;
        row_nxt = '0;
        if (accept) begin
          unique case (op_t'(in_operation))
            OP_CLEAR: state_nxt = S_CLEAR;
            OP_DRAW: begin
              if (draw_bad || (width_use == '0) || (height_use == '0)) begin
                state_nxt = S_FINISH;
              end else begin
                state_nxt = S_DRAW;
              end
            end
            OP_READ: state_nxt = S_READ;
            default: state_nxt = S_FINISH;
          endcase
        end
      end
      S_CLEAR: begin
        col_nxt = col_r + SIDE_W'(1);
        if (&col_r) begin
          row_nxt = row_r + SIDE_W'(1);
          if (&row_r) begin
            state_nxt = S_FINISH;
          end
        end
      end
      S_DRAW: begin
        if (col_last) begin
          col_nxt = '0;
          row_nxt = row_r + SIDE_W'(1);
          if (row_last) begin
            state_nxt = S_FINISH;
          end
        end else begin
          col_nxt = col_r + SIDE_W'(1);
        end
      end
      S_READ: state_nxt = S_FINISH;
      S_FINISH: begin
        if (out_load) begin
          state_nxt = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  // State, control and output registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= S_IDLE;
      col_r        <= '0;
      row_r        <= '0;
      out_valid_r  <= 1'b0;
      out_status_r <= 1'b0;
      out_pixel_r  <= '0;
      cfg_width_r  <= '0;
      cfg_height_r <= '0;
      background_r <= BACKGROUND_RESET;
    end else begin
      state_r      <= state_nxt;
      col_r        <= col_nxt;
      row_r        <= row_nxt;
      out_valid_r  <= out_valid_nxt;
      cfg_width_r  <= cfg_width_nxt;
      cfg_height_r <= cfg_height_nxt;
      background_r <= background_nxt;
      if (out_load) begin
        out_status_r <= res_status_r;
        out_pixel_r  <= res_pixel_r;
      end
    end
  end

  // Transaction payload, draw bounds and pending result.
  always_ff @(posedge clk) begin
    if (accept) begin
      left_r      <= ext_left;
      right_r     <= ext_left + ext_w;
      top_r       <= ext_top;
      bottom_r    <= ext_top + ext_h;
      left_in_r   <= ext_left + ONE_UNIT;
      right_in_r  <= ext_left + ext_w - ONE_UNIT;
      top_in_r    <= ext_top + ONE_UNIT;
      bottom_in_r <= ext_top + ext_h - ONE_UNIT;
      filled_r    <= (in_shape_kind == KIND_FILLED);
      color_r     <= in_color;
      in_range_r  <= ({1'b0, in_read_col} < width_use) && ({1'b0, in_read_row} < height_use);
      res_status_r <= (op_t'(in_operation) == OP_DRAW) && draw_bad;
      res_pixel_r  <= '0;
    end
    // The registered RAM read is valid in the cycle after the address.
    if (state_r == S_READ) begin
      res_pixel_r <= in_range_r ? ram_rdata : '0;
    end
  end

  // Assertions.
  `RRP_ASSERT_IMP(a_we_in_write_states, clk, rst_n, ram_we,
                  (state_r == S_CLEAR || state_r == S_DRAW))
  `RRP_ASSERT_IMP(a_draw_in_canvas, clk, rst_n, ram_we && (state_r == S_DRAW),
                  ({1'b0, col_r} < width_use) && ({1'b0, row_r} < height_use))
  `RRP_ASSERT_IMP(a_reject_no_pixel, clk, rst_n, out_valid_r && out_status_r,
                  out_pixel_r == '0)
  `RRP_ASSERT_NXT(a_busy_after_accept, clk, rst_n, accept, in_stall)

endmodule

[hw/rtl/rrp_ram.sv]
// ----------------------------------------------------------------------------
// Rectangle raster painter RAM
// Generic single-write, single-read synchronous RAM with registered read.
// ----------------------------------------------------------------------------
module rrp_ram #(
  parameter int DATA_W = 8,
  parameter int DEPTH  = 256,
  parameter int ADDR_W = $clog2(DEPTH)
) (
  input  logic              clk,
  input  logic              we,
  input  logic [ADDR_W-1:0] waddr,
  input  logic [DATA_W-1:0] wdata,
  input  logic [ADDR_W-1:0] raddr,
  output logic [DATA_W-1:0] rdata
);

  logic [DATA_W-1:0] mem [DEPTH];

  // Write port and registered read port.
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

[test/rectangle_raster_painter_tb.sv]
// ----------------------------------------------------------------------------
// Rectangle raster painter testbench
// Drives clear, draw, read and idle transactions through the valid/stall
// channels under several canvas settings and compares every result with a
// canvas model kept in a scoreboard class.
// ----------------------------------------------------------------------------
module rectangle_raster_painter_tb
  import rrp_pkg::*;
();
  timeunit 1ns;
  timeprecision 1ps;

  localparam int UNIT = 1 << FRAC_BITS;
  localparam int COORD_MAX = (1 << (COORD_W - 1)) - 1;
  localparam logic [CFG_IDX_W-1:0] CFG_UNUSED = 2'd3;
  localparam int NUM_PHASES = 9;

  typedef struct {
    op_t                      op;
    logic [7:0]               kind;
    logic signed [COORD_W-1:0] left;
    logic signed [COORD_W-1:0] top;
    logic signed [COORD_W-1:0] w;
    logic signed [COORD_W-1:0] h;
    logic [PIX_W-1:0]         color;
    logic [SIDE_W-1:0]        col;
    logic [SIDE_W-1:0]        row;
  } paint_txn_t;

  typedef struct {
    logic             status;
    logic [PIX_W-1:0] pixel;
  } paint_result_t;

  // Canvas model: keeps its own copy of the registers and the pixel store.
  class canvas_scoreboard;
    logic [PIX_W-1:0]      canvas [MAX_SIDE*MAX_SIDE];
    logic [CFG_DATA_W-1:0] cols_reg = '0;
    logic [CFG_DATA_W-1:0] rows_reg = '0;
    logic [PIX_W-1:0]      bg = BACKGROUND_RESET;
    paint_result_t         due_q[$];
    int errors = 0;
    int compared = 0;
    int n_clear = 0, n_draw = 0, n_reject = 0, n_read = 0, n_nop = 0;

    function void write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] val);
      case (idx)
        CFG_CANVAS_WIDTH:  cols_reg = val;
        CFG_CANVAS_HEIGHT: rows_reg = val;
        CFG_BACKGROUND:    bg = val[PIX_W-1:0];
        default: ;
      endcase
    endfunction

    function int cols_used();
      return (cols_reg > MAX_SIDE) ? MAX_SIDE : int'(cols_reg);
    endfunction

    function int rows_used();
      return (rows_reg > MAX_SIDE) ? MAX_SIDE : int'(rows_reg);
    endfunction

    // Paints one rectangle into the model; returns 1 when the draw is rejected.
    function bit paint(paint_txn_t req);
      int  l, tp, r, b, px, py;
      bit  on_border;
      if (req.w <= 0 || req.h <= 0 ||
          (req.kind != KIND_FILLED && req.kind != KIND_OUTLINE)) begin
        return 1'b1;
      end
      l  = req.left;
      tp = req.top;
      r  = l + int'(req.w);
      b  = tp + int'(req.h);
      for (int x = 0; x < cols_used(); x++) begin
        for (int y = 0; y < rows_used(); y++) begin
          px = x * UNIT;
          py = y * UNIT;
          if (px >= l && px <= r && py >= tp && py <= b) begin
            // A pixel closer than one unit to any edge is border.
            on_border = (px - l < UNIT) || (r - px < UNIT) ||
                        (py - tp < UNIT) || (b - py < UNIT);
            if (on_border || req.kind == KIND_FILLED) begin
              canvas[y*MAX_SIDE + x] = req.color;
            end
          end
        end
      end
      return 1'b0;
    endfunction

    // Applies an accepted input transaction and queues its result.
    function void note_input(paint_txn_t req);
      paint_result_t res;
      res.status = 1'b0;
      res.pixel  = '0;
      case (req.op)
        OP_CLEAR: begin
          foreach (canvas[i]) canvas[i] = bg;
          n_clear++;
        end
        OP_DRAW: begin
          res.status = paint(req);
          if (res.status) n_reject++;
          else n_draw++;
        end
        OP_READ: begin
          n_read++;
          if (int'(req.col) < cols_used() && int'(req.row) < rows_used()) begin
            res.pixel = canvas[int'(req.row)*MAX_SIDE + int'(req.col)];
          end
        end
        default: n_nop++;
      endcase
      due_q.push_back(res);
    endfunction

    // Compares one result transaction with the oldest outstanding one.
    function void check(logic status, logic [PIX_W-1:0] pixel);
      paint_result_t exp_res;
      if (due_q.size() == 0) begin
        $error("unexpected result transaction: status %0d, pixel 0x%02h", status, pixel);
        errors++;
        return;
      end
      exp_res = due_q.pop_front();
      compared++;
      if (status !== exp_res.status) begin
        $error("status mismatch: expected %0d, actual %0d", exp_res.status, status);
        errors++;
      end
      if (pixel !== exp_res.pixel) begin
        $error("pixel mismatch: expected 0x%02h, actual 0x%02h", exp_res.pixel, pixel);
        errors++;
      end
    endfunction
  endclass

  logic                      clk = 1'b0;
  logic                      rst_n = 1'b0;
  logic                      cfg_we = 1'b0;
  logic [CFG_IDX_W-1:0]      cfg_index = '0;
  logic [CFG_DATA_W-1:0]     cfg_wdata = '0;
  logic                      in_valid = 1'b0;
  logic                      in_stall;
  logic [1:0]                in_operation = '0;
  logic [7:0]                in_shape_kind = '0;
  logic signed [COORD_W-1:0] in_rect_left = '0;
  logic signed [COORD_W-1:0] in_rect_top = '0;
  logic signed [COORD_W-1:0] in_rect_w = '0;
  logic signed [COORD_W-1:0] in_rect_h = '0;
  logic [PIX_W-1:0]          in_color = '0;
  logic [SIDE_W-1:0]         in_read_col = '0;
  logic [SIDE_W-1:0]         in_read_row = '0;
  logic                      out_valid;
  logic                      out_stall = 1'b0;
  logic                      out_status;
  logic [PIX_W-1:0]          out_pixel;

  canvas_scoreboard board;
  bit                idle_on = 1'b1;
  int unsigned       stall_hold = 0;

  // Canvas settings of the random phases: columns, rows, background, idling, clear, item count.
  int ph_cols  [NUM_PHASES] = '{16, 1, 0, 511, 5, 256, 40, 7, 23};
  int ph_rows  [NUM_PHASES] = '{12, 1, 256, 3, 300, 256, 25, 9, 31};
  int ph_bg    [NUM_PHASES] = '{8'h00, 8'hFF, 8'h5A, 8'h3C, 8'h81, 8'h20, 8'hC3, 8'h96, 8'h0F};
  bit ph_idle  [NUM_PHASES] = '{1, 1, 1, 0, 1, 1, 1, 0, 1};
  bit ph_clear [NUM_PHASES] = '{1, 1, 0, 1, 1, 1, 1, 0, 0};
  int ph_items [NUM_PHASES] = '{10, 6, 4, 8, 8, 4, 12, 8, 10};

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  rectangle_raster_painter i_dut (
    .clk           (clk),
    .rst_n         (rst_n),
    .cfg_we        (cfg_we),
    .cfg_index     (cfg_index),
    .cfg_wdata     (cfg_wdata),
    .in_valid      (in_valid),
    .in_stall      (in_stall),
    .in_operation  (in_operation),
    .in_shape_kind (in_shape_kind),
    .in_rect_left  (in_rect_left),
    .in_rect_top   (in_rect_top),
    .in_rect_w     (in_rect_w),
    .in_rect_h     (in_rect_h),
    .in_color      (in_color),
    .in_read_col   (in_read_col),
    .in_read_row   (in_read_row),
    .out_valid     (out_valid),
    .out_stall     (out_stall),
    .out_status    (out_status),
    .out_pixel     (out_pixel)
  );

  // Idle stretch length: mostly short, now and then long.
  function automatic int gap_len();
    return ($urandom_range(0, 9) < 8) ? $urandom_range(1, 3) : $urandom_range(10, 40);
  endfunction

  // Random stalls on the result channel, held for random stretches.
  always @(posedge clk) begin
    if (stall_hold != 0) begin
      stall_hold <= stall_hold - 1;
    end else begin
      stall_hold <= gap_len();
      out_stall  <= idle_on && ($urandom_range(0, 2) == 0);
    end
  end

  // Every accepted result transaction goes to the scoreboard.
  always @(posedge clk) begin
    if (rst_n && out_valid && !out_stall) begin
      board.check(out_status, out_pixel);
    end
  end

  // A transaction with every field random.
  function automatic paint_txn_t rand_fill();
    paint_txn_t t;
    t.op    = op_t'($urandom_range(0, 3));
    t.kind  = 8'($urandom);
    t.left  = COORD_W'($urandom);
    t.top   = COORD_W'($urandom);
    t.w     = COORD_W'($urandom);
    t.h     = COORD_W'($urandom);
    t.color = PIX_W'($urandom);
    t.col   = SIDE_W'($urandom);
    t.row   = SIDE_W'($urandom);
    return t;
  endfunction

  function automatic paint_txn_t mk_op(op_t op);
    paint_txn_t t;
    t    = rand_fill();
    t.op = op;
    return t;
  endfunction

  function automatic paint_txn_t mk_read(int c, int r);
    paint_txn_t t;
    t     = mk_op(OP_READ);
    t.col = SIDE_W'(c);
    t.row = SIDE_W'(r);
    return t;
  endfunction

  function automatic paint_txn_t mk_draw(logic [7:0] kind, int l, int tp, int w, int h,
                                         logic [PIX_W-1:0] color);
    paint_txn_t t;
    t       = mk_op(OP_DRAW);
    t.kind  = kind;
    t.left  = COORD_W'(l);
    t.top   = COORD_W'(tp);
    t.w     = COORD_W'(w);
    t.h     = COORD_W'(h);
    t.color = color;
    return t;
  endfunction

  // Corner coordinate around the canvas in use; half of them on whole pixels.
  function automatic logic signed [COORD_W-1:0] rand_pos(int span);
    int v;
    v = int'($urandom_range(0, (span + 4) * UNIT)) - 2 * UNIT;
    if ($urandom_range(0, 1)) v = v & ~(UNIT - 1);
    if (v > COORD_MAX) v = COORD_MAX;
    return COORD_W'(v);
  endfunction

  // Positive extent, often small, half of them whole pixels.
  function automatic logic signed [COORD_W-1:0] rand_extent(int span);
    int v;
    if ($urandom_range(0, 3) == 0) v = $urandom_range(1, 600);
    else v = $urandom_range(1, (span + 2) * UNIT);
    if ($urandom_range(0, 1)) v = v & ~(UNIT - 1);
    if (v == 0) v = UNIT;
    if (v > COORD_MAX) v = COORD_MAX;
    return COORD_W'(v);
  endfunction

  // Random transaction: mostly well-formed draws and reads, some noise.
  function automatic paint_txn_t rand_txn();
    paint_txn_t t;
    int pick, cols, rows;
    t    = rand_fill();
    cols = board.cols_used();
    rows = board.rows_used();
    pick = $urandom_range(0, 99);
    if (pick < 8) begin
      // Noise keeps off the slow clear.
      if (t.op == OP_CLEAR) t.op = OP_DRAW;
    end else if (pick < 52) begin
      t.op   = OP_DRAW;
      t.kind = $urandom_range(0, 1) ? KIND_FILLED : KIND_OUTLINE;
      if ($urandom_range(0, 9) == 0) t.kind = 8'($urandom);
      t.left = rand_pos(cols);
      t.top  = rand_pos(rows);
      t.w    = rand_extent(cols);
      t.h    = rand_extent(rows);
      if ($urandom_range(0, 19) == 0) t.w = COORD_W'(-int'($urandom_range(0, 65536)));
      if ($urandom_range(0, 19) == 0) t.h = COORD_W'(-int'($urandom_range(0, 65536)));
    end else if (pick < 93) begin
      t.op = OP_READ;
      if ($urandom_range(0, 5) != 0) begin
        t.col = SIDE_W'($urandom_range(0, (cols > 255) ? 255 : cols));
        t.row = SIDE_W'($urandom_range(0, (rows > 255) ? 255 : rows));
      end
    end else begin
      t.op = OP_NOP;
    end
    return t;
  endfunction

  // Sends one input transaction, after a random gap, and records it once accepted.
  task automatic send(paint_txn_t t);
    int gap;
    gap = (!idle_on || $urandom_range(0, 1)) ? 0 : gap_len();
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid      <= 1'b1;
    in_operation  <= t.op;
    in_shape_kind <= t.kind;
    in_rect_left  <= t.left;
    in_rect_top   <= t.top;
    in_rect_w     <= t.w;
    in_rect_h     <= t.h;
    in_color      <= t.color;
    in_read_col   <= t.col;
    in_read_row   <= t.row;
    do @(posedge clk); while (in_stall);
    board.note_input(t);
  endtask

  // Waits until every outstanding result has come back.
  task automatic drain();
    in_valid <= 1'b0;
    while (board.due_q.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic write_cfg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] val);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= val;
    @(posedge clk);
    board.write_reg(idx, val);
  endtask

  // Writes all registers, plus the unused index, which the block ignores.
  task automatic set_canvas(int cols, int rows, int bgv);
    write_cfg(CFG_CANVAS_WIDTH, CFG_DATA_W'(cols));
    write_cfg(CFG_CANVAS_HEIGHT, CFG_DATA_W'(rows));
    write_cfg(CFG_BACKGROUND, CFG_DATA_W'(bgv));
    write_cfg(CFG_UNUSED, CFG_DATA_W'($urandom));
    cfg_we <= 1'b0;
  endtask

  // Run limit.
  initial begin
    #(24_000_000);
    $display("rectangle_raster_painter_tb: errors");
    $finish;
  end

  initial begin
    board = new;
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Reset settings: empty canvas in use, so reads and draws touch nothing.
    send(mk_op(OP_CLEAR));
    send(mk_read(0, 0));
    send(mk_draw(KIND_FILLED, 0, 0, 4 * UNIT, 4 * UNIT, 8'h44));
    send(mk_op(OP_NOP));
    drain();

    // Directed part on a 16 by 12 canvas.
    set_canvas(16, 12, 8'hA5);
    send(mk_op(OP_CLEAR));
    send(mk_read(0, 0));
    send(mk_read(15, 11));
    send(mk_read(16, 0));
    send(mk_read(0, 12));
    send(mk_read(255, 255));
    send(mk_draw(KIND_FILLED, 512, 384, 1280, 1088, 8'h11));
    send(mk_draw(KIND_OUTLINE, -384, -128, 5120, 768, 8'hEE));
    // Outline thinner than one unit: a single pixel.
    send(mk_draw(KIND_OUTLINE, 10 * UNIT, 8 * UNIT, 128, 128, 8'hFF));
    // Rejected: zero width, negative height, unknown kinds.
    send(mk_draw(KIND_FILLED, 0, 0, 0, UNIT, 8'h77));
    send(mk_draw(KIND_FILLED, 0, 0, UNIT, -65536, 8'h77));
    send(mk_draw(8'h00, 0, 0, UNIT, UNIT, 8'h77));
    send(mk_draw(8'hFF, 0, 0, UNIT, UNIT, 8'h77));
    // Extreme corners that leave the canvas untouched.
    send(mk_draw(KIND_FILLED, -65536, -65536, 65535, 65535, 8'h00));
    send(mk_draw(KIND_OUTLINE, 65535, 65535, 1, 1, 8'h00));
    send(mk_read(4, 3));
    send(mk_read(2, 2));
    send(mk_read(10, 8));
    // Huge outline from the origin: only the first row and column change.
    send(mk_draw(KIND_OUTLINE, 0, 0, 65535, 65535, 8'h00));
    send(mk_read(0, 5));
    send(mk_op(OP_NOP));
    drain();

    // Random phases over several canvas settings.
    for (int p = 0; p < NUM_PHASES; p++) begin
      set_canvas(ph_cols[p], ph_rows[p], ph_bg[p]);
      idle_on = ph_idle[p];
      if (ph_clear[p]) send(mk_op(OP_CLEAR));
      repeat (ph_items[p]) send(rand_txn());
      drain();
    end
    repeat (16) @(posedge clk);

    $display("Covered %0d clears, %0d painted draws, %0d rejected draws, %0d reads, %0d no-ops.",
             board.n_clear, board.n_draw, board.n_reject, board.n_read, board.n_nop);
    $display("Compared %0d result transactions over %0d canvas settings.",
             board.compared, NUM_PHASES + 2);
    if (board.errors == 0 && board.due_q.size() == 0) begin
      $display("rectangle_raster_painter_tb: clean");
    end else begin
      $display("rectangle_raster_painter_tb: errors");
    end
    $finish;
  end

endmodule
